@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check that cond never holds at a rising clk edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ src/qrpt_pkg.sv @@
// Package for the quaternion rigid point transform: register codes,
// transform modes, quaternion type and component index tables. No dependencies.
package qrpt_pkg;

  localparam int unsigned QUAT_W = 16;
  typedef logic signed [QUAT_W-1:0] quat_t;

  // Transform order codes
  localparam logic [1:0] MODE_ROT       = 2'd0;
  localparam logic [1:0] MODE_ROT_SHIFT = 2'd1;
  localparam logic [1:0] MODE_SHIFT_ROT = 2'd2;

  // Register index codes
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_X  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_Y  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_Z  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_W  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Z = 3'd7;

  // Quaternion identity scalar in Q1.14
  localparam quat_t QUAT_W_RESET = 16'sd16384;

  // Cyclic component neighbors for the cross products
  localparam int unsigned NXT [3] = '{1, 2, 0};
  localparam int unsigned PRV [3] = '{2, 0, 1};

endpackage

@@ src/quaternion_rigid_point_transform.sv @@
// Top level of the quaternion rigid point transform: APB register file and
// a five-stage rotate/translate pipeline. Depends on qrpt_pkg and assert_macros.svh.
//
//  Channel | Ports                                     | Transaction when
//  --------+-------------------------------------------+-------------------------------
//  input   | in_valid, in_stall, in_x, in_y, in_z      | in_valid high, in_stall low
//  result  | out_valid, out_stall, out_x, out_y, out_z | out_valid high, out_stall low
//  config  | psel, penable, pwrite, paddr, pwdata, ... | psel, penable, pwrite high
//
// One point per cycle while the result side is not stalled; each point
// passes through translate-in, first cross product, split products,
// recombine and round/saturate before it shows on the result side.
// rst_n is synchronous: it empties the pipeline and loads identity settings.
// A stage holds only while the stage behind it is full and blocked, so a
// stalled result stops the input only once every stage holds a point.

`include "assert_macros.svh"

module quaternion_rigid_point_transform #(
  parameter int unsigned COORD_WIDTH    = 32,
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qrpt_pkg::REG_IDX_W + ((COORD_WIDTH > 32) ? 3 : 2) - 1:0] paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32) - 1:0] pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32) - 1:0] prdata,
  output logic                          pready
);

  localparam int unsigned C   = COORD_WIDTH;
  localparam int unsigned QW  = qrpt_pkg::QUAT_W;
  localparam int unsigned DW  = (C > 32) ? 64 : 32;       // register data width
  localparam int unsigned AS  = (C > 32) ? 3 : 2;         // byte offset bits
  localparam int unsigned RS  = 2 * QUAT_FRAC_BITS;       // fraction bits to drop
  localparam int unsigned PW  = C + 1;                    // point after pre-shift
  localparam int unsigned TW  = C + 18;                   // first cross product
  localparam int unsigned TL  = TW / 2;                   // low split, unsigned
  localparam int unsigned TH  = TW - TL;                  // high split, signed
  localparam int unsigned PLW = TL + 19;                  // low partial sum
  localparam int unsigned PHW = TH + 18;                  // high partial sum
  localparam int unsigned UW  = C + 37;                   // second stage sum
  localparam int unsigned BW  = C + 2;                    // point plus shift
  localparam int unsigned SW  = ((BW + RS > UW + 1) ? BW + RS : UW + 1) + 1;
  localparam int unsigned RW  = SW - RS;                  // rounded width

  localparam logic signed [SW-1:0] HALF_LSB = SW'(1) << (RS - 1);
  localparam logic signed [C-1:0]  SAT_MAX  = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0]  SAT_MIN  = {1'b1, {(C-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]              mode_r;
  qrpt_pkg::quat_t         quat_r [3];   // x, y, z
  qrpt_pkg::quat_t         quat_w_r;
  logic signed [C-1:0]     shift_r [3];
  logic [qrpt_pkg::REG_IDX_W-1:0] reg_idx;
  logic                    cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[qrpt_pkg::REG_IDX_W + AS - 1:AS];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= qrpt_pkg::MODE_ROT;
      quat_w_r <= qrpt_pkg::QUAT_W_RESET;
      for (int i = 0; i < 3; i++) begin
        quat_r[i]  <= '0;
        shift_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        qrpt_pkg::REG_MODE:    mode_r     <= pwdata[1:0];
        qrpt_pkg::REG_QUAT_X:  quat_r[0]  <= pwdata[QW-1:0];
        qrpt_pkg::REG_QUAT_Y:  quat_r[1]  <= pwdata[QW-1:0];
        qrpt_pkg::REG_QUAT_Z:  quat_r[2]  <= pwdata[QW-1:0];
        qrpt_pkg::REG_QUAT_W:  quat_w_r   <= pwdata[QW-1:0];
        qrpt_pkg::REG_SHIFT_X: shift_r[0] <= pwdata[C-1:0];
        qrpt_pkg::REG_SHIFT_Y: shift_r[1] <= pwdata[C-1:0];
        qrpt_pkg::REG_SHIFT_Z: shift_r[2] <= pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      qrpt_pkg::REG_MODE:    prdata = DW'(mode_r);
      qrpt_pkg::REG_QUAT_X:  prdata = DW'($unsigned(quat_r[0]));
      qrpt_pkg::REG_QUAT_Y:  prdata = DW'($unsigned(quat_r[1]));
      qrpt_pkg::REG_QUAT_Z:  prdata = DW'($unsigned(quat_r[2]));
      qrpt_pkg::REG_QUAT_W:  prdata = DW'($unsigned(quat_w_r));
      qrpt_pkg::REG_SHIFT_X: prdata = DW'($unsigned(shift_r[0]));
      qrpt_pkg::REG_SHIFT_Y: prdata = DW'($unsigned(shift_r[1]));
      qrpt_pkg::REG_SHIFT_Z: prdata = DW'($unsigned(shift_r[2]));
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its
  // occupant moves on in the same cycle.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the point, add the shift first in translate-then-rotate
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] p1_nxt [3];
  logic signed [PW-1:0] p1_r   [3];
  logic signed [C-1:0]  pin    [3];

  assign pin[0] = in_x;
  assign pin[1] = in_y;
  assign pin[2] = in_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (mode_r == qrpt_pkg::MODE_SHIFT_ROT) begin
        p1_nxt[i] = PW'(pin[i]) + PW'(shift_r[i]);
      end else begin
        p1_nxt[i] = PW'(pin[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 3; i++) p1_r[i] <= p1_nxt[i];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: t = q x p
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] t2_nxt [3];
  logic signed [TW-1:0] t2_r   [3];
  logic signed [PW-1:0] p2_r   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t2_nxt[i] = TW'(quat_r[qrpt_pkg::NXT[i]]) * TW'(p1_r[qrpt_pkg::PRV[i]])
                - TW'(quat_r[qrpt_pkg::PRV[i]]) * TW'(p1_r[qrpt_pkg::NXT[i]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < 3; i++) begin
        t2_r[i] <= t2_nxt[i];
        p2_r[i] <= p1_r[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: w*t + q x t, with t split in a low unsigned and a high signed
  // half so each multiplier stays narrow
  // --------------------------------------------------------------------------
  logic signed [TL:0]    tlo    [3];
  logic signed [TH-1:0]  thi    [3];
  logic signed [PLW-1:0] pl3_nxt [3];
  logic signed [PHW-1:0] ph3_nxt [3];
  logic signed [PLW-1:0] pl3_r  [3];
  logic signed [PHW-1:0] ph3_r  [3];
  logic signed [PW-1:0]  p3_r   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tlo[i] = $signed({1'b0, t2_r[i][TL-1:0]});
      thi[i] = t2_r[i][TW-1:TL];
    end
    for (int i = 0; i < 3; i++) begin
      pl3_nxt[i] = PLW'(quat_w_r) * PLW'(tlo[i])
                 + PLW'(quat_r[qrpt_pkg::NXT[i]]) * PLW'(tlo[qrpt_pkg::PRV[i]])
                 - PLW'(quat_r[qrpt_pkg::PRV[i]]) * PLW'(tlo[qrpt_pkg::NXT[i]]);
      ph3_nxt[i] = PHW'(quat_w_r) * PHW'(thi[i])
                 + PHW'(quat_r[qrpt_pkg::NXT[i]]) * PHW'(thi[qrpt_pkg::PRV[i]])
                 - PHW'(quat_r[qrpt_pkg::PRV[i]]) * PHW'(thi[qrpt_pkg::NXT[i]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int i = 0; i < 3; i++) begin
        pl3_r[i] <= pl3_nxt[i];
        ph3_r[i] <= ph3_nxt[i];
        p3_r[i]  <= p2_r[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: recombine the halves; add the shift after rotation if selected
  // --------------------------------------------------------------------------
  logic signed [UW-1:0] u4_nxt    [3];
  logic signed [BW-1:0] base4_nxt [3];
  logic signed [UW-1:0] u4_r      [3];
  logic signed [BW-1:0] base4_r   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u4_nxt[i] = (UW'(ph3_r[i]) <<< TL) + UW'(pl3_r[i]);
      if (mode_r == qrpt_pkg::MODE_ROT_SHIFT) begin
        base4_nxt[i] = BW'(p3_r[i]) + BW'(shift_r[i]);
      end else begin
        base4_nxt[i] = BW'(p3_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int i = 0; i < 3; i++) begin
        u4_r[i]    <= u4_nxt[i];
        base4_r[i] <= base4_nxt[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: exact sum, round half up, saturate
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] sum5    [3];
  logic signed [RW-1:0] rnd5    [3];
  logic [RW-C:0]        hi5     [3];
  logic signed [C-1:0]  out_nxt [3];
  logic signed [C-1:0]  out_r   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // base has zero fraction bits, so the rounding half just fills one in
      sum5[i] = ((SW'(base4_r[i]) <<< RS) | HALF_LSB) + (SW'(u4_r[i]) <<< 1);
      rnd5[i] = sum5[i][SW-1:RS];
      hi5[i]  = rnd5[i][RW-1:C-1];
      if ((&hi5[i]) || !(|hi5[i])) begin
        out_nxt[i] = rnd5[i][C-1:0];
      end else if (rnd5[i][RW-1]) begin
        out_nxt[i] = SAT_MIN;
      end else begin
        out_nxt[i] = SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      for (int i = 0; i < 3; i++) out_r[i] <= out_nxt[i];
    end
  end

  assign out_valid = v5_r;
  assign out_x     = out_r[0];
  assign out_y     = out_r[1];
  assign out_z     = out_r[2];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an empty front stage never pushes back on the input
  `ASSERT_NEVER(a_stall_when_empty, clk, rst_n, in_stall && !v1_r)
  // a point in the front stage moves on when the next stage takes it
  `ASSERT_CLK(a_front_advance, clk, rst_n, v1_r && rdy2 |=> v2_r)
  // a blocked result keeps the point behind it in place
  `ASSERT_CLK(a_hold_behind_result, clk, rst_n, v5_r && out_stall && v4_r |=> v4_r && v5_r)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for quaternion_rigid_point_transform: a scoreboard class
// predicts each transformed point, and plain tasks drive the point stream and APB writes.
// Depends on qrpt_pkg and the RTL top level only.

module tb_top;

  localparam int COORD_W = 32;
  localparam int QFRAC   = 14;

  // Mode code that the block treats as rotate only
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  // Quaternions packed as {x, y, z, w}, Q1.14
  localparam logic [63:0] UNIT_QUATS [6] = '{
    {16'sd0,     16'sd0,    16'sd0,     16'sd16384},  // identity
    {16'sd0,     16'sd0,    16'sd11585, 16'sd11585},  // 90 degrees about z
    {16'sd11585, 16'sd0,    16'sd0,     16'sd11585},  // 90 degrees about x
    {16'sd0,     16'sd16384, 16'sd0,    16'sd0},      // 180 degrees about y
    {16'sd8192,  16'sd8192, 16'sd8192,  16'sd8192},   // 120 degrees about the diagonal
    {-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192}
  };

  typedef logic signed [127:0] wide_t;
  typedef struct { logic signed [COORD_W-1:0] x, y, z; } point_t;

  // Predicts transformed points from its own copy of the registers and
  // holds the results that the block still owes, oldest first.
  class point_transform_board_t;
    logic [1:0]                mode;
    qrpt_pkg::quat_t           qx, qy, qz, qw;
    logic signed [COORD_W-1:0] sx, sy, sz;
    point_t                    awaited[$];
    int                        mismatches;
    int                        points_checked;

    function new();
      mode = qrpt_pkg::MODE_ROT;
      qx = '0; qy = '0; qz = '0; qw = qrpt_pkg::QUAT_W_RESET;
      sx = '0; sy = '0; sz = '0;
      mismatches = 0;
      points_checked = 0;
    endfunction

    function void set_reg(logic [qrpt_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        qrpt_pkg::REG_MODE:    mode = value[1:0];
        qrpt_pkg::REG_QUAT_X:  qx = value[15:0];
        qrpt_pkg::REG_QUAT_Y:  qy = value[15:0];
        qrpt_pkg::REG_QUAT_Z:  qz = value[15:0];
        qrpt_pkg::REG_QUAT_W:  qw = value[15:0];
        qrpt_pkg::REG_SHIFT_X: sx = value;
        qrpt_pkg::REG_SHIFT_Y: sy = value;
        qrpt_pkg::REG_SHIFT_Z: sz = value;
        default: ;
      endcase
    endfunction

    // Exact arithmetic, one round half up and one saturation at the end.
    function point_t transform_point(point_t p);
      wide_t  a[3], sh[3], t[3], u[3], s[3];
      wide_t  wx, wy, wz, ww, r;
      logic signed [COORD_W-1:0] c[3];
      point_t res;
      a[0] = p.x;  a[1] = p.y;  a[2] = p.z;
      sh[0] = sx;  sh[1] = sy;  sh[2] = sz;
      wx = qx;  wy = qy;  wz = qz;  ww = qw;
      // Pre-rotation sum keeps one extra bit, no saturation here
      if (mode == qrpt_pkg::MODE_SHIFT_ROT)
        for (int i = 0; i < 3; i++) a[i] = a[i] + sh[i];
      t[0] = wy * a[2] - wz * a[1];
      t[1] = wz * a[0] - wx * a[2];
      t[2] = wx * a[1] - wy * a[0];
      u[0] = ww * t[0] + wy * t[2] - wz * t[1];
      u[1] = ww * t[1] + wz * t[0] - wx * t[2];
      u[2] = ww * t[2] + wx * t[1] - wy * t[0];
      for (int i = 0; i < 3; i++) begin
        s[i] = (a[i] <<< (2 * QFRAC)) + u[i] + u[i];
        if (mode == qrpt_pkg::MODE_ROT_SHIFT) s[i] = s[i] + (sh[i] <<< (2 * QFRAC));
        r = (s[i] + (wide_t'(1) <<< (2 * QFRAC - 1))) >>> (2 * QFRAC);
        if (r > wide_t'(C_MAX)) r = C_MAX;
        else if (r < wide_t'(C_MIN)) r = C_MIN;
        c[i] = r[COORD_W-1:0];
      end
      res.x = c[0];  res.y = c[1];  res.z = c[2];
      return res;
    endfunction

    function void note_point(point_t p);
      awaited.push_back(transform_point(p));
    endfunction

    function void compare_field(string name, logic signed [COORD_W-1:0] want,
                                logic signed [COORD_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                 $time, name, want, want, got, got);
      end
    endfunction

    function void check_result(point_t got);
      point_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result (%0d, %0d, %0d), expected none",
                 $time, got.x, got.y, got.z);
        return;
      end
      want = awaited.pop_front();
      points_checked++;
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("out_z", want.z, got.z);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid, in_stall;
  logic signed [COORD_W-1:0] in_x, in_y, in_z;
  logic                      out_valid, out_stall;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic                      psel, penable, pwrite, pready;
  logic [4:0]                paddr;
  logic [31:0]               pwdata, prdata;

  point_transform_board_t board = new();
  int settings_count = 0;
  int result_hold_left = 0;  // armed by the stimulus, counted down by the receiver

  always #5 clk = ~clk;

  quaternion_rigid_point_transform u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Sample both channels at the rising edge; a result cannot come from a
  // point taken at the same edge, so the order of the two checks is free.
  always @(posedge clk) begin : transaction_monitor
    point_t seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen.x = out_x;  seen.y = out_y;  seen.z = out_z;
        board.check_result(seen);
      end
      if (in_valid && !in_stall) begin
        seen.x = in_x;  seen.y = in_y;  seen.z = in_z;
        board.note_point(seen);
      end
    end
  end

  // Result side: switch between stall styles of random length; a pending
  // long hold overrides the pattern until its count runs out.
  initial begin : result_receiver
    int style;
    int style_left;
    int tick;
    out_stall = 1'b0;
    style = 0;
    style_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (result_hold_left > 0) begin
        out_stall <= 1'b1;
        result_hold_left--;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(0, 3);
          style_left = $urandom_range(20, 150);
        end
        style_left--;
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // Uniform integer in [-half, half]
  function automatic int small_signed(int half);
    return signed'($urandom_range(0, 2 * half)) - half;
  endfunction

  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(0, 4))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // Half full-range values, the rest small magnitudes and edge values
  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom();
      5, 6, 7: return small_signed(1 << 20);
      8: return extreme_coord();
      default: return small_signed(1 << 17);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] random_shift();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return $urandom();
      2: return small_signed(1 << 22);
      default: return $urandom_range(0, 1) ? C_MAX : C_MIN;
    endcase
  endfunction

  function automatic logic [63:0] random_quat();
    logic [15:0] qc[4];
    case ($urandom_range(0, 5))
      0, 1: return UNIT_QUATS[$urandom_range(0, 5)];
      2: return {$urandom(), $urandom()};
      3: begin
        // near identity: small vector part, w at or just below one
        for (int i = 0; i < 3; i++) qc[i] = 16'(small_signed(3000));
        qc[3] = 16'(16384 - int'($urandom_range(0, 2000)));
      end
      default: for (int i = 0; i < 4; i++) qc[i] = 16'(small_signed(16384));
    endcase
    return {qc[0], qc[1], qc[2], qc[3]};
  endfunction

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(logic [qrpt_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write every register; fill the unused upper bits of the narrow ones with noise
  task automatic set_transform(logic [1:0] mode, logic [63:0] quat,
                               logic [31:0] shx, logic [31:0] shy, logic [31:0] shz);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(qrpt_pkg::REG_MODE, {junk[31:2], mode});
    junk = $urandom();
    write_reg(qrpt_pkg::REG_QUAT_X, {junk[31:16], quat[63:48]});
    junk = $urandom();
    write_reg(qrpt_pkg::REG_QUAT_Y, {junk[31:16], quat[47:32]});
    junk = $urandom();
    write_reg(qrpt_pkg::REG_QUAT_Z, {junk[31:16], quat[31:16]});
    junk = $urandom();
    write_reg(qrpt_pkg::REG_QUAT_W, {junk[31:16], quat[15:0]});
    write_reg(qrpt_pkg::REG_SHIFT_X, shx);
    write_reg(qrpt_pkg::REG_SHIFT_Y, shy);
    write_reg(qrpt_pkg::REG_SHIFT_Z, shz);
    settings_count++;
  endtask

  // Offer one point and hold it until the block takes it; valid stays high
  task automatic offer_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
    @(negedge clk);
    in_valid <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Drop valid and put noise on the idle payload
  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_x <= $urandom();
      in_y <= $urandom();
      in_z <= $urandom();
    end
  endtask

  // Pause the sender until every awaited result has come, then let the pipe settle
  task automatic drain_results();
    idle_input(1);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Bursts of random length separated by random gaps, sometimes none
  task automatic run_random_points(int count);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        idle_input(gap);
      end
      offer_point(random_coord(), random_coord(), random_coord());
      burst_left--;
    end
  endtask

  initial begin : stimulus
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_x     = '0;
    in_y     = '0;
    in_z     = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: identity quaternion, rotate only
    offer_point('0, '0, '0);
    offer_point(C_MAX, C_MIN, -1);
    offer_point(1, -1, 32'sh0001_0000);
    drain_results();

    // Rotate then translate by extreme shifts: saturates both ways
    set_transform(qrpt_pkg::MODE_ROT_SHIFT, UNIT_QUATS[1], C_MAX, C_MAX, C_MIN);
    offer_point(C_MAX, C_MAX, C_MAX);
    offer_point(C_MIN, '0, C_MAX);
    offer_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
    drain_results();

    // Translate then rotate with a non-unit quaternion at the component
    // limits; the shifted point overflows a coordinate before rotation
    set_transform(qrpt_pkg::MODE_SHIFT_ROT,
                  {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff},
                  C_MIN, C_MIN, C_MAX);
    offer_point(C_MIN, C_MIN, C_MAX);
    offer_point(C_MAX, C_MAX, C_MIN);
    offer_point(-1, -1, -1);
    drain_results();

    // Unused mode code behaves as rotate only
    set_transform(MODE_SPARE, UNIT_QUATS[4], 32'sh0001_8000, -5, 7);
    offer_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    offer_point(C_MAX, '0, C_MIN);
    drain_results();

    // Pure-vector quaternion x = 2^-2: rotation term is exactly half an
    // LSB of the result, so these land on the round-half cases
    set_transform(qrpt_pkg::MODE_ROT, {16'sd4096, 16'sd0, 16'sd0, 16'sd0}, '0, '0, '0);
    offer_point('0, 4, '0);
    offer_point('0, -4, '0);
    offer_point(4, 4, 4);
    drain_results();

    // All components at the negative limit
    set_transform(qrpt_pkg::MODE_ROT, {4{16'sh8000}}, '0, '0, '0);
    offer_point(C_MAX, C_MAX, C_MAX);
    offer_point(C_MIN, C_MIN, C_MIN);
    drain_results();

    // Random phases, each under fresh settings
    for (int phase = 0; phase < 8; phase++) begin
      set_transform(2'($urandom_range(0, 3)), random_quat(),
                    random_shift(), random_shift(), random_shift());
      if (phase == 2) begin
        // Hold off results long enough to fill every stage; keep offering
        // so the input side has to stall
        result_hold_left = 80;
        repeat (30) offer_point(random_coord(), random_coord(), random_coord());
      end
      run_random_points(105);
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d points under %0d register settings, all four mode codes,",
             board.points_checked, settings_count + 1);
    $display("with saturation, round-half ties, a long result hold and drained pauses.");
    if (board.mismatches == 0) begin
      $display("[quaternion_rigid_point_transform] OK");
    end else begin
      $display("[quaternion_rigid_point_transform] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d results still awaited", board.awaited.size());
    $display("[quaternion_rigid_point_transform] ERROR");
    $finish;
  end

endmodule
